// File: rtl/pffm_pkg.sv
// ----------------------------------------------------------------------------
// pffm_pkg
// Shared types and constants for the power fault flag manager: flag bit
// positions, operation and severity codes, register indexes and the records
// passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package pffm_pkg;

    // Flag vector.
    localparam int FLAG_W = 14;
    typedef logic [FLAG_W-1:0] flags_t;

    localparam flags_t FLAG_HIGH_POWER = 14'h0002;
    localparam flags_t FLAG_OC         = 14'h0004;
    localparam flags_t FLAG_OV         = 14'h0008;
    localparam flags_t FLAG_UV         = 14'h0010;
    localparam flags_t FLAG_OP         = 14'h0020;
    localparam flags_t FLAG_MONITORED  = 14'h07FF;
    localparam flags_t FLAG_CRITICAL   = 14'h3A3C;

    // Operation codes.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_RAISE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Severity codes.
    localparam logic [1:0] SEV_INFO = 2'd0;
    localparam logic [1:0] SEV_WARN = 2'd1;
    localparam logic [1:0] SEV_CRIT = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_OC_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UV_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_DISC = 3'd4;

    // Measurement thresholds: 1 V minimum voltage, 30 mA no-load current.
    localparam logic [15:0] MIN_VOLTS  = 16'd100;
    localparam logic [16:0] NO_LOAD_MA = 17'd30;

    // Queue between front and back end.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [15:0] oc_limit;
        logic [19:0] op_limit;
        logic [15:0] ov_limit;
        logic [15:0] uv_limit;
        logic        auto_disconnect;
    } cfg_t;

    // Classified item: everything that depends only on the input and limits.
    typedef struct packed {
        logic [1:0] op;
        flags_t     thr_flags;
        logic       hp_set;
        logic       hp_release;
        logic       no_load_hit;
        flags_t     req_flags;
        logic [1:0] req_sev;
    } item_t;

    typedef struct packed {
        flags_t     raised;
        flags_t     cleared;
        flags_t     active;
        logic [1:0] severity;
        logic       open_req;
        logic       crit_latch;
        logic       high_power;
        logic       no_load_seen;
    } result_t;

endpackage

// File: rtl/pffm_front.sv
// ----------------------------------------------------------------------------
// pffm_front
// Classifies an incoming item: current and power magnitudes, the four
// threshold checks, the high-power set and release conditions, the no-load
// condition and the clamped request severity.
// ----------------------------------------------------------------------------
module pffm_front
    import pffm_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [1:0]         op,
    input  logic [15:0]        rms_voltage,
    input  logic signed [16:0] rms_current,
    input  logic signed [20:0] real_power,
    input  logic               relay_is_shut,
    input  logic [13:0]        request_flags,
    input  logic [1:0]         request_severity,
    output item_t              item
);

    logic [16:0] cur_mag;
    logic [20:0] pwr_mag;
    logic [25:0] pwr_ext;
    logic [25:0] plim_ext;
    logic [21:0] cur_ext;
    logic [21:0] clim_ext;
    logic        p_en;
    logic        c_en;
    logic        hi;
    logic        lo;
    logic        volts_ok;

    // Magnitudes of the signed measurements.
    assign cur_mag = rms_current[16] ? $unsigned(-rms_current) : $unsigned(rms_current);
    assign pwr_mag = real_power[20] ? $unsigned(-real_power) : $unsigned(real_power);

    assign pwr_ext  = 26'(pwr_mag);
    assign plim_ext = 26'(cfg.op_limit);
    assign cur_ext  = 22'(cur_mag);
    assign clim_ext = 22'(cfg.oc_limit);

    assign p_en     = (cfg.op_limit != '0);
    assign c_en     = (cfg.oc_limit != '0);
    assign volts_ok = (rms_voltage > MIN_VOLTS);

    // High-power hysteresis: set at 90 percent, release below 85 percent.
    assign hi = (p_en && (pwr_ext * 26'd10 >= plim_ext * 26'd9))
             || (c_en && (cur_ext * 22'd10 >= clim_ext * 22'd9));
    assign lo = (!p_en || (pwr_ext * 26'd20 < plim_ext * 26'd17))
             && (!c_en || (cur_ext * 22'd20 < clim_ext * 22'd17));

    // Threshold flags and request fields.
    always_comb
    begin
        item.op          = op;
        item.thr_flags   = '0;
        if (c_en && (cur_mag > 17'(cfg.oc_limit)))
        begin
            item.thr_flags = item.thr_flags | FLAG_OC;
        end
        if (p_en && (pwr_mag > 21'(cfg.op_limit)))
        begin
            item.thr_flags = item.thr_flags | FLAG_OP;
        end
        if ((cfg.ov_limit != '0) && (rms_voltage > cfg.ov_limit))
        begin
            item.thr_flags = item.thr_flags | FLAG_OV;
        end
        if ((cfg.uv_limit != '0) && volts_ok && (rms_voltage < cfg.uv_limit))
        begin
            item.thr_flags = item.thr_flags | FLAG_UV;
        end
        item.hp_set      = hi;
        item.hp_release  = lo;
        item.no_load_hit = relay_is_shut && volts_ok && (cur_mag <= NO_LOAD_MA);
        item.req_flags   = request_flags;
        item.req_sev     = (request_severity > SEV_CRIT) ? SEV_CRIT : request_severity;
    end

endmodule

// File: rtl/pffm_queue.sv
// ----------------------------------------------------------------------------
// pffm_queue
// Short first-in first-out queue of classified items between the front end
// and the back end.
// ----------------------------------------------------------------------------
module pffm_queue
    import pffm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output item_t head_item
);

    item_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/pffm_back.sv
// ----------------------------------------------------------------------------
// pffm_back
// Applies one classified item to the fault state: no-load debounce,
// high-power hysteresis, raise and clear of active and latched flags and the
// relay critical latch. The result is held in an output register.
// ----------------------------------------------------------------------------
module pffm_back
    import pffm_pkg::*;
#(
    parameter int NO_LOAD_SAMPLES = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    auto_disconnect,
    input  logic    head_valid,
    input  item_t   head_item,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    localparam int NL_W = $clog2(NO_LOAD_SAMPLES + 1);
    localparam logic [NL_W-1:0] NL_TARGET = NL_W'(NO_LOAD_SAMPLES);

    flags_t          active_reg;
    flags_t          active_next;
    flags_t          latched_reg;
    flags_t          latched_next;
    logic            relay_reg;
    logic            relay_next;
    logic            hp_reg;
    logic            hp_next;
    logic [NL_W-1:0] nl_run_reg;
    logic [NL_W-1:0] nl_run_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    result_t         result_reg;
    result_t         result_next;

    flags_t          sample_flags;
    flags_t          prior_flags;
    flags_t          rise;
    flags_t          fall;
    flags_t          act_mid;
    flags_t          lat_mid;
    logic            relay_mid;

    // Take the next item when the output register is free or being drained.
    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // State update and result for the item at the head of the queue.
    always_comb
    begin
        active_next  = active_reg;
        latched_next = latched_reg;
        relay_next   = relay_reg;
        hp_next      = hp_reg;
        nl_run_next  = nl_run_reg;
        sample_flags = '0;
        prior_flags  = '0;
        rise         = '0;
        fall         = '0;
        act_mid      = active_reg;
        lat_mid      = latched_reg;
        relay_mid    = relay_reg;
        result_next  = '0;

        case (head_item.op)
            OP_SAMPLE:
            begin
                // No-load debounce counter.
                if (head_item.no_load_hit)
                begin
                    if (nl_run_reg < NL_TARGET)
                    begin
                        nl_run_next = nl_run_reg + NL_W'(1);
                    end
                end
                else
                begin
                    nl_run_next = '0;
                end
                // High-power hysteresis.
                if (!hp_reg && head_item.hp_set)
                begin
                    hp_next = 1'b1;
                end
                else if (hp_reg && head_item.hp_release)
                begin
                    hp_next = 1'b0;
                end
                sample_flags = head_item.thr_flags | (hp_next ? FLAG_HIGH_POWER : '0);
                prior_flags  = (active_reg | latched_reg) & FLAG_MONITORED;
                rise         = sample_flags & ~prior_flags;
                fall         = prior_flags & ~sample_flags;
                // Raise first; a critical raise latches all raised flags.
                act_mid = active_reg | rise;
                if ((rise & FLAG_CRITICAL) != '0)
                begin
                    lat_mid   = latched_reg | rise;
                    relay_mid = 1'b1;
                end
                // Then clear the flags that dropped out.
                active_next  = act_mid & ~fall;
                latched_next = lat_mid & ~fall;
                relay_next   = relay_mid;
                if ((fall != '0) && ((latched_next & FLAG_CRITICAL) == '0))
                begin
                    relay_next = 1'b0;
                end
                result_next.raised  = rise;
                result_next.cleared = fall;
                if (rise != '0)
                begin
                    if ((rise & FLAG_CRITICAL) != '0)
                    begin
                        result_next.severity = SEV_CRIT;
                        result_next.open_req = auto_disconnect;
                    end
                    else
                    begin
                        result_next.severity = SEV_WARN;
                    end
                end
            end
            OP_RAISE:
            begin
                rise = head_item.req_flags & ~active_reg;
                if (rise != '0)
                begin
                    active_next = active_reg | rise;
                    if ((head_item.req_sev == SEV_CRIT) || ((rise & FLAG_CRITICAL) != '0))
                    begin
                        latched_next = latched_reg | rise;
                        relay_next   = 1'b1;
                    end
                    result_next.severity = head_item.req_sev;
                end
                result_next.raised = rise;
            end
            OP_CLEAR:
            begin
                fall         = (active_reg | latched_reg) & head_item.req_flags;
                active_next  = active_reg & ~fall;
                latched_next = latched_reg & ~fall;
                if ((fall != '0) && ((latched_next & FLAG_CRITICAL) == '0))
                begin
                    relay_next = 1'b0;
                end
                result_next.cleared = fall;
            end
            default:
            begin
            end
        endcase

        result_next.active       = active_next | latched_next;
        result_next.crit_latch   = relay_next;
        result_next.high_power   = hp_next;
        result_next.no_load_seen = (nl_run_next >= NL_TARGET);
    end

    // Output valid: set by a new result, dropped by a transfer.
    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            latched_reg   <= '0;
            relay_reg     <= 1'b0;
            hp_reg        <= 1'b0;
            nl_run_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                active_reg  <= active_next;
                latched_reg <= latched_next;
                relay_reg   <= relay_next;
                hp_reg      <= hp_next;
                nl_run_reg  <= nl_run_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: rtl/power_fault_flag_manager.sv
// ----------------------------------------------------------------------------
// power_fault_flag_manager
// Turns measurement samples and external raise and clear requests into fault
// flag events: raised, cleared and active masks plus relay latch status.
// ----------------------------------------------------------------------------
// Path: each item is classified into the queue, then applied to the fault
// state into the output register, where it waits for out_ready.
// Throughput: one item per cycle while out_ready is high; the two-entry queue
// and the output register let the input side keep going while a result waits,
// until the queue is full.
// Reset: asynchronous; clears limits, fault state, queue and output valid.
module power_fault_flag_manager
    import pffm_pkg::*;
#(
    parameter int NO_LOAD_SAMPLES = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic [15:0]           rms_voltage,
    input  logic signed [16:0]    rms_current,
    input  logic signed [20:0]    real_power,
    input  logic                  relay_is_shut,
    input  logic [13:0]           request_flags,
    input  logic [1:0]            request_severity,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [13:0]           raised_mask,
    output logic [13:0]           cleared_mask,
    output logic [13:0]           active_mask,
    output logic [1:0]            event_severity,
    output logic                  open_relay_request,
    output logic                  critical_latch,
    output logic                  high_power_state,
    output logic                  no_load_seen
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    item_t   front_item;
    item_t   head_item;
    logic    queue_full;
    logic    head_valid;
    logic    pop;
    result_t result;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_OC_LIMIT:  cfg_next.oc_limit        = cfg_wdata[15:0];
                CFG_OP_LIMIT:  cfg_next.op_limit        = cfg_wdata[19:0];
                CFG_OV_LIMIT:  cfg_next.ov_limit        = cfg_wdata[15:0];
                CFG_UV_LIMIT:  cfg_next.uv_limit        = cfg_wdata[15:0];
                CFG_AUTO_DISC: cfg_next.auto_disconnect = cfg_wdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready = !queue_full;

    // Front end: classification of the incoming item.
    pffm_front u_front (
        .cfg              (cfg_reg),
        .op               (op),
        .rms_voltage      (rms_voltage),
        .rms_current      (rms_current),
        .real_power       (real_power),
        .relay_is_shut    (relay_is_shut),
        .request_flags    (request_flags),
        .request_severity (request_severity),
        .item             (front_item)
    );

    // Queue between the two halves.
    pffm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && in_ready),
        .push_item  (front_item),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: fault state and result register.
    pffm_back #(
        .NO_LOAD_SAMPLES (NO_LOAD_SAMPLES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .auto_disconnect (cfg_reg.auto_disconnect),
        .head_valid      (head_valid),
        .head_item       (head_item),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result          (result)
    );

    assign raised_mask        = result.raised;
    assign cleared_mask       = result.cleared;
    assign active_mask        = result.active;
    assign event_severity     = result.severity;
    assign open_relay_request = result.open_req;
    assign critical_latch     = result.crit_latch;
    assign high_power_state   = result.high_power;
    assign no_load_seen       = result.no_load_seen;

`ifndef SYNTHESIS
    // A relay opening request only comes with a critical raise.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && open_relay_request |-> (event_severity == SEV_CRIT))
        else $error("open request without critical severity");

    // One item never raises and clears the same flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((raised_mask & cleared_mask) == '0))
        else $error("flag both raised and cleared");

    // Raised flags are active after the item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((raised_mask & ~active_mask) == '0))
        else $error("raised flag not active");

    // Without a raise there is no severity and no opening request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (raised_mask == '0) |-> (event_severity == SEV_INFO) && !open_relay_request)
        else $error("severity reported without a raise");
`endif

endmodule
